// ----- hw/rtl/tsrs_pkg.sv -----
// Shared types and constants for the time sync retry scheduler.
// No dependencies; used by tsrs_step and time_sync_retry_scheduler_top.
package tsrs_pkg;

    localparam int unsigned ElapsedW  = 30;
    localparam int unsigned TimeW     = 32;
    localparam int unsigned IntervalW = 20;
    localparam int unsigned RetryW    = 2;
    localparam int unsigned TimeoutW  = 16;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 32;

    localparam logic [ElapsedW-1:0]  ElapsedMax      = '1;
    localparam logic [ElapsedW-1:0]  BackoffStepMs   = ElapsedW'(500);
    localparam logic [ElapsedW-1:0]  MsPerSec        = ElapsedW'(1000);
    localparam logic [IntervalW-1:0] IntervalMin     = IntervalW'(60);
    localparam logic [IntervalW-1:0] IntervalMax     = IntervalW'(604800);
    localparam logic [ElapsedW-1:0]  IntervalMsReset = ElapsedW'(21600000);
    localparam logic [RetryW-1:0]    MaxRetriesReset = RetryW'(3);
    localparam logic [RetryW-1:0]    MaxRetriesMin   = RetryW'(1);
    localparam logic [TimeoutW-1:0]  TimeoutReset    = TimeoutW'(10000);
    localparam logic [TimeoutW-1:0]  TimeoutMin      = TimeoutW'(1);
    localparam logic [TimeW-1:0]     MinValidReset   = TimeW'(1600000000);

    localparam logic [CfgIdxW-1:0] CFG_INTERVAL  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RETRIES   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT   = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_MIN_VALID = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ACTIVE  = 2'd1,
        PH_BACKOFF = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_REQ   = 3'd1,
        ST_DONE  = 3'd2,
        ST_FAIL  = 3'd3,
        ST_NONET = 3'd4,
        ST_RETRY = 3'd5
    } t_status;

    typedef struct packed {
        t_phase              phase;
        logic [ElapsedW-1:0] elapsed;
        logic [ElapsedW-1:0] wait_ms;
        logic [RetryW-1:0]   attempt;
        logic                fresh;
        logic                last_ok;
        logic [TimeW-1:0]    last_sync;
        t_status             status;
    } t_state;

    typedef struct packed {
        logic [ElapsedW-1:0] interval_ms;
        logic [RetryW-1:0]   max_retries;
        logic [TimeoutW-1:0] timeout_ms;
        logic [TimeW-1:0]    min_valid;
    } t_cfg;

    typedef struct packed {
        logic             action;
        logic             network_up;
        logic             sync_event;
        logic [TimeW-1:0] wall_time;
    } t_item;

    typedef struct packed {
        logic start_req;
        logic stop_req;
        logic accepted;
    } t_flags;

endpackage

// ----- hw/rtl/tsrs_step.sv -----
// Next-state logic for one beat of the retry scheduler.
// Depends on tsrs_pkg (state, config, item and flag types).
module tsrs_step import tsrs_pkg::*; (
    input  t_state i_state,
    input  t_cfg   i_cfg,
    input  t_item  i_item,
    output t_state o_state,
    output t_flags o_flags
);

    logic [ElapsedW-1:0] el_inc;
    logic                do_start;
    logic                do_end;
    logic                end_ok;
    t_state              s;
    t_flags              f;

    assign el_inc = (i_state.elapsed != ElapsedMax) ? i_state.elapsed + 1'b1
                                                    : i_state.elapsed;

    always_comb begin
        s        = i_state;
        f        = '{start_req: 1'b0, stop_req: 1'b0, accepted: 1'b1};
        do_start = 1'b0;
        do_end   = 1'b0;
        end_ok   = 1'b0;
        if (i_item.sync_event) begin
            s.fresh = 1'b1;
        end

        if (!i_item.action) begin
            s.elapsed = el_inc;
            if (!i_item.network_up) begin
                if (i_state.phase != PH_IDLE) begin
                    f.stop_req = 1'b1;
                    s.phase    = PH_IDLE;
                    s.last_ok  = 1'b0;
                end
                s.wait_ms = '0;
                s.status  = ST_NONET;
            end else begin
                unique case (i_state.phase)
                    PH_ACTIVE: begin
                        if (s.fresh && (i_item.wall_time > i_cfg.min_valid)) begin
                            do_end = 1'b1;
                            end_ok = 1'b1;
                        end else if (el_inc >= ElapsedW'(i_cfg.timeout_ms)) begin
                            f.stop_req = 1'b1;
                            if (i_state.attempt >= i_cfg.max_retries) begin
                                do_end = 1'b1;
                            end else begin
                                s.phase   = PH_BACKOFF;
                                s.elapsed = '0;
                                s.wait_ms = ElapsedW'(i_state.attempt) * BackoffStepMs;
                                s.status  = ST_RETRY;
                            end
                        end
                    end
                    PH_BACKOFF: begin
                        do_start = (el_inc >= i_state.wait_ms);
                    end
                    default: begin
                        // idle; a stray phase code behaves the same
                        if (el_inc >= i_state.wait_ms) begin
                            s.attempt = '0;
                            do_start  = 1'b1;
                        end
                    end
                endcase
            end
        end else begin
            if (!i_item.network_up) begin
                s.status   = ST_NONET;
                f.accepted = 1'b0;
            end else if (i_state.phase != PH_ACTIVE && i_state.phase != PH_BACKOFF) begin
                s.attempt = '0;
                do_start  = 1'b1;
            end
        end

        if (do_start) begin
            f.stop_req  = 1'b1;
            f.start_req = 1'b1;
            s.fresh     = 1'b0;
            s.attempt   = s.attempt + 1'b1;
            s.phase     = PH_ACTIVE;
            s.elapsed   = '0;
            s.last_ok   = 1'b0;
            s.status    = ST_REQ;
        end

        if (do_end) begin
            f.stop_req = 1'b1;
            s.phase    = PH_IDLE;
            s.elapsed  = '0;
            s.wait_ms  = i_cfg.interval_ms;
            s.last_ok  = end_ok;
            if (end_ok) begin
                s.last_sync = i_item.wall_time;
                s.status    = ST_DONE;
            end else begin
                s.status    = ST_FAIL;
            end
        end
    end

    assign o_state = s;
    assign o_flags = f;

endmodule

// ----- hw/rtl/time_sync_retry_scheduler_top.sv -----
// Time sync retry scheduler: idle / active / backoff sequencing per 1 ms tick.
// Datapath: input register then result register; the input register refills while a
// result waits, and holds its beat while the result register is full and not read.
// Throughput: one beat per cycle while i_out_ready is high.
// Reset: synchronous, active low; clears state, config to defaults, both stages empty.
// Depends on tsrs_pkg and tsrs_step.
module time_sync_retry_scheduler_top import tsrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write port
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_action,
    input  logic                i_network_up,
    input  logic                i_sync_event,
    input  logic [TimeW-1:0]    i_wall_time,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_phase,
    output logic [RetryW-1:0]   o_attempt_number,
    output logic                o_last_ok,
    output logic [TimeW-1:0]    o_last_sync_time,
    output logic [2:0]          o_status_code,
    output logic                o_start_request,
    output logic                o_stop_request,
    output logic                o_accepted
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_item  r_item;
    t_flags r_flags;
    t_flags n_flags;
    logic   r_in_valid;
    logic   r_out_valid;
    logic   advance;

    logic [IntervalW-1:0] cfg_interval;
    logic [RetryW-1:0]    cfg_retries;
    logic [TimeoutW-1:0]  cfg_timeout;

    // config clamps
    always_comb begin
        cfg_interval = i_cfg_data[IntervalW-1:0];
        if (cfg_interval < IntervalMin) begin
            cfg_interval = IntervalMin;
        end else if (cfg_interval > IntervalMax) begin
            cfg_interval = IntervalMax;
        end
        cfg_retries = i_cfg_data[RetryW-1:0];
        if (cfg_retries < MaxRetriesMin) begin
            cfg_retries = MaxRetriesMin;
        end
        cfg_timeout = i_cfg_data[TimeoutW-1:0];
        if (cfg_timeout < TimeoutMin) begin
            cfg_timeout = TimeoutMin;
        end
    end

    // interval kept in ms so the round wait is a plain load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval_ms <= IntervalMsReset;
            r_cfg.max_retries <= MaxRetriesReset;
            r_cfg.timeout_ms  <= TimeoutReset;
            r_cfg.min_valid   <= MinValidReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INTERVAL:  r_cfg.interval_ms <= ElapsedW'(cfg_interval) * MsPerSec;
                CFG_RETRIES:   r_cfg.max_retries <= cfg_retries;
                CFG_TIMEOUT:   r_cfg.timeout_ms  <= cfg_timeout;
                CFG_MIN_VALID: r_cfg.min_valid   <= i_cfg_data[TimeW-1:0];
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= '{action: i_action, network_up: i_network_up,
                        sync_event: i_sync_event, wall_time: i_wall_time};
        end
    end

    tsrs_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (r_item),
        .o_state (n_state),
        .o_flags (n_flags)
    );

    // state only moves when the result register loads, so it doubles as the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_IDLE, elapsed: '0, wait_ms: '0, attempt: '0,
                             fresh: 1'b0, last_ok: 1'b0, last_sync: '0,
                             status: ST_NONE};
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_flags <= n_flags;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_phase          = r_state.phase;
    assign o_attempt_number = r_state.attempt;
    assign o_last_ok        = r_state.last_ok;
    assign o_last_sync_time = r_state.last_sync;
    assign o_status_code    = r_state.status;
    assign o_start_request  = r_flags.start_req;
    assign o_stop_request   = r_flags.stop_req;
    assign o_accepted       = r_flags.accepted;

endmodule

// ----- sim/tb_time_sync_retry_scheduler_top.sv -----
// Self-checking bench for time_sync_retry_scheduler_top: drives ticks and sync requests,
// predicts every result beat in step with the block. Depends on tsrs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_time_sync_retry_scheduler_top;
    import tsrs_pkg::*;

    localparam int WatchdogLimit = 2000;

    typedef struct packed {
        t_phase            phase;
        logic [RetryW-1:0] tries;
        logic              last_ok;
        logic [TimeW-1:0]  last_sync;
        t_status           status;
        logic              start_req;
        logic              stop_req;
        logic              accepted;
    } t_sched_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_action;
    logic                i_network_up;
    logic                i_sync_event;
    logic [TimeW-1:0]    i_wall_time;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [1:0]          o_phase;
    logic [RetryW-1:0]   o_attempt_number;
    logic                o_last_ok;
    logic [TimeW-1:0]    o_last_sync_time;
    logic [2:0]          o_status_code;
    logic                o_start_request;
    logic                o_stop_request;
    logic                o_accepted;

    // shadow configuration
    logic [IntervalW-1:0] cfg_interval_s;
    logic [RetryW-1:0]    cfg_max_tries;
    logic [TimeoutW-1:0]  cfg_timeout_ms;
    logic [TimeW-1:0]     cfg_min_wall;

    // shadow scheduler state
    t_phase              m_phase;
    logic [ElapsedW-1:0] m_elapsed;
    logic [ElapsedW-1:0] m_wait;
    logic [RetryW-1:0]   m_tries;
    logic                m_fresh;
    logic                m_last_ok;
    logic [TimeW-1:0]    m_last_sync;
    t_status             m_status;
    logic                m_start;
    logic                m_stop;

    t_sched_result sched_expect_q[$];
    int            errors = 0;
    int            quiet_cycles = 0;
    bit            idle_en = 1'b0;

    time_sync_retry_scheduler_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_network_up     (i_network_up),
        .i_sync_event     (i_sync_event),
        .i_wall_time      (i_wall_time),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_phase          (o_phase),
        .o_attempt_number (o_attempt_number),
        .o_last_ok        (o_last_ok),
        .o_last_sync_time (o_last_sync_time),
        .o_status_code    (o_status_code),
        .o_start_request  (o_start_request),
        .o_stop_request   (o_stop_request),
        .o_accepted       (o_accepted)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function void open_attempt();
        m_stop    = 1'b1;
        m_fresh   = 1'b0;
        m_tries   = m_tries + 1'b1;
        m_phase   = PH_ACTIVE;
        m_elapsed = '0;
        m_last_ok = 1'b0;
        m_status  = ST_REQ;
        m_start   = 1'b1;
    endfunction

    function void close_round(input logic ok, input logic [TimeW-1:0] wall);
        m_stop    = 1'b1;
        m_phase   = PH_IDLE;
        m_elapsed = '0;
        m_wait    = ElapsedW'(cfg_interval_s) * MsPerSec;
        m_last_ok = ok;
        if (ok) begin
            m_last_sync = wall;
            m_status    = ST_DONE;
        end else begin
            m_status = ST_FAIL;
        end
    endfunction

    function void predict_schedule(input logic act, input logic net, input logic ev,
                                   input logic [TimeW-1:0] wall);
        t_sched_result r;
        logic          taken;
        taken   = 1'b1;
        m_start = 1'b0;
        m_stop  = 1'b0;
        // event is latched before any attempt start can clear it
        if (ev) m_fresh = 1'b1;
        if (!act) begin
            if (m_elapsed != ElapsedMax) m_elapsed = m_elapsed + 1'b1;
            if (!net) begin
                if (m_phase != PH_IDLE) begin
                    m_stop    = 1'b1;
                    m_phase   = PH_IDLE;
                    m_last_ok = 1'b0;
                end
                m_wait   = '0;
                m_status = ST_NONET;
            end else if (m_phase == PH_ACTIVE) begin
                if (m_fresh && wall > cfg_min_wall) begin
                    close_round(1'b1, wall);
                end else if (m_elapsed >= cfg_timeout_ms) begin
                    m_stop = 1'b1;
                    if (m_tries >= cfg_max_tries) begin
                        close_round(1'b0, wall);
                    end else begin
                        m_phase   = PH_BACKOFF;
                        m_elapsed = '0;
                        m_wait    = BackoffStepMs * m_tries;
                        m_status  = ST_RETRY;
                    end
                end
            end else if (m_phase == PH_BACKOFF) begin
                if (m_elapsed >= m_wait) open_attempt();
            end else begin
                if (m_elapsed >= m_wait) begin
                    m_tries = '0;
                    open_attempt();
                end
            end
        end else begin
            if (!net) begin
                m_status = ST_NONET;
                taken    = 1'b0;
            end else if (m_phase != PH_ACTIVE && m_phase != PH_BACKOFF) begin
                m_tries = '0;
                open_attempt();
            end
        end
        r.phase     = m_phase;
        r.tries     = m_tries;
        r.last_ok   = m_last_ok;
        r.last_sync = m_last_sync;
        r.status    = m_status;
        r.start_req = m_start;
        r.stop_req  = m_stop;
        r.accepted  = taken;
        sched_expect_q.push_back(r);
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        errors++;
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    endtask

    // sends one beat; called and returns at a falling edge
    task automatic send_item(input logic act, input logic net, input logic ev,
                             input logic [TimeW-1:0] wall);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_network_up <= net;
        i_sync_event <= ev;
        i_wall_time  <= wall;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_schedule(act, net, ev, wall);
        @(negedge i_clk);
    endtask

    // waits until every predicted result is checked, then idles before touching registers
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sched_expect_q.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        logic [IntervalW-1:0] iv;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_INTERVAL: begin
                iv = data[IntervalW-1:0];
                if (iv < IntervalMin) iv = IntervalMin;
                else if (iv > IntervalMax) iv = IntervalMax;
                cfg_interval_s = iv;
            end
            CFG_RETRIES:
                cfg_max_tries = (data[RetryW-1:0] == '0) ? MaxRetriesMin : data[RetryW-1:0];
            CFG_TIMEOUT:
                cfg_timeout_ms = (data[TimeoutW-1:0] == '0) ? TimeoutMin : data[TimeoutW-1:0];
            default:
                cfg_min_wall = data;
        endcase
    endtask

    task automatic check_basic_sequencing();
        logic [TimeW-1:0] mv;
        mv = MinValidReset;
        send_item(1'b1, 1'b0, 1'b0, 32'h0);          // refused without network
        send_item(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_item(1'b1, 1'b1, 1'b0, mv + 1);         // start clears the earlier event
        send_item(1'b1, 1'b1, 1'b0, 32'h0);          // request while active
        send_item(1'b0, 1'b1, 1'b1, mv);             // wall equal to threshold: no success
        send_item(1'b0, 1'b1, 1'b0, mv + 1);
        send_item(1'b0, 1'b1, 1'b0, 32'h0);
        send_item(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);  // event in starting beat does not count
        send_item(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_item(1'b0, 1'b0, 1'b0, 32'h5);          // link loss while active
        send_item(1'b0, 1'b1, 1'b0, 32'h5);          // zero wait: restart at once
        send_item(1'b0, 1'b1, 1'b1, 32'hAAAA_AAAA);
        send_item(1'b0, 1'b0, 1'b0, 32'h0);          // link loss while idle
        send_item(1'b1, 1'b1, 1'b0, 32'h5555_5555);
        send_item(1'b1, 1'b1, 1'b1, 32'h1234_5678);
        send_item(1'b0, 1'b0, 1'b1, 32'h8000_0000);
        send_item(1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF);
    endtask

    task automatic check_register_clamping();
        wait_drained();
        write_reg(CFG_TIMEOUT, 32'h0);
        write_reg(CFG_RETRIES, 32'h0);
        write_reg(CFG_MIN_VALID, 32'hFFFF_FFFF);
        write_reg(CFG_INTERVAL, 32'h0);
        send_item(1'b0, 1'b0, 1'b0, 32'h1);
        send_item(1'b0, 1'b1, 1'b0, 32'h2);
        send_item(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);  // times out after one tick, one try
        send_item(1'b1, 1'b1, 1'b0, 32'h3);
        send_item(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(CFG_RETRIES, 32'h4);
        write_reg(CFG_TIMEOUT, 32'h1_0000);
        write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_VALID, 32'h0);
        send_item(1'b1, 1'b1, 1'b0, 32'h0);
        send_item(1'b0, 1'b1, 1'b1, 32'h1);
        send_item(1'b0, 1'b1, 1'b0, 32'h2);
        wait_drained();
        write_reg(CFG_RETRIES, 32'h7);
        write_reg(CFG_TIMEOUT, 32'hFFFF);
        write_reg(CFG_INTERVAL, 32'd604801);
        write_reg(CFG_INTERVAL, 32'd59);
        send_item(1'b1, 1'b1, 1'b0, 32'h0);
        send_item(1'b0, 1'b1, 1'b1, 32'h0);
        send_item(1'b0, 1'b0, 1'b0, 32'h0);
    endtask

    task automatic check_retry_rounds();
        logic act;
        for (int n = 0; n < 4; n++) begin
            wait_drained();
            write_reg(CFG_RETRIES, CfgDataW'(n));
            write_reg(CFG_TIMEOUT, CfgDataW'($urandom_range(1, 3)));
            write_reg(CFG_MIN_VALID, 32'hFFFF_FFFF);
            write_reg(CFG_INTERVAL, 32'd60);
            send_item(1'b0, 1'b0, 1'b0, $urandom);
            do begin
                act = (m_phase == PH_BACKOFF) && ($urandom_range(0, 49) == 0);
                send_item(act, 1'b1, 1'($urandom_range(0, 1)), $urandom);
            end while (m_status != ST_FAIL);
        end
        // recovery on the second try; success wins over a timeout on the same tick
        wait_drained();
        write_reg(CFG_RETRIES, 32'd3);
        write_reg(CFG_TIMEOUT, 32'd2);
        write_reg(CFG_MIN_VALID, 32'd1000);
        send_item(1'b0, 1'b0, 1'b0, 32'h0);
        do send_item(1'b0, 1'b1, 1'b0, 32'($urandom_range(0, 1000)));
        while (m_phase != PH_BACKOFF);
        send_item(1'b1, 1'b1, 1'b0, 32'd5000);
        do send_item(1'b0, 1'b1, 1'($urandom_range(0, 1)), $urandom);
        while (m_phase != PH_ACTIVE);
        send_item(1'b0, 1'b1, 1'b0, 32'd2000);
        send_item(1'b0, 1'b1, 1'b1, 32'd1001);
    endtask

    task automatic check_random_traffic();
        int               sent;
        int               len;
        logic [TimeW-1:0] wall;
        logic             act;
        logic             net;
        sent = 0;
        while (sent < 700) begin
            wait_drained();
            idle_en = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 4))
                0:       write_reg(CFG_INTERVAL, 32'h0);
                1:       write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
                2:       write_reg(CFG_INTERVAL, CfgDataW'(IntervalMax));
                default: write_reg(CFG_INTERVAL, $urandom);
            endcase
            write_reg(CFG_RETRIES, $urandom);
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_TIMEOUT, 32'h0);
                1:       write_reg(CFG_TIMEOUT, $urandom);
                default: write_reg(CFG_TIMEOUT, CfgDataW'($urandom_range(1, 40)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_MIN_VALID, 32'h0);
                1:       write_reg(CFG_MIN_VALID, 32'hFFFF_FFFF);
                default: write_reg(CFG_MIN_VALID, $urandom);
            endcase
            send_item(1'b1, 1'b1, 1'b0, $urandom);
            sent++;
            len = $urandom_range(40, 90);
            for (int k = 0; k < len; k++) begin
                // wall hovers around the threshold, now and then anywhere
                if ($urandom_range(0, 9) == 0) wall = $urandom;
                else wall = cfg_min_wall - 32'd32 + 32'($urandom_range(0, 64));
                act = ($urandom_range(0, 15) == 0);
                net = ($urandom_range(0, 29) != 0);
                send_item(act, net, 1'($urandom_range(0, 7) == 0), wall);
                sent++;
                // sometimes ride out a backoff so the next try gets exercised
                if (m_phase == PH_BACKOFF && $urandom_range(0, 39) == 0) begin
                    while (m_phase == PH_BACKOFF)
                        send_item(1'b0, 1'b1, 1'($urandom_range(0, 1)), $urandom);
                end
            end
        end
    endtask

    task automatic check_interval_expiry();
        wait_drained();
        idle_en = 1'b0;
        write_reg(CFG_INTERVAL, 32'h0);
        write_reg(CFG_TIMEOUT, 32'd1);
        write_reg(CFG_MIN_VALID, 32'h0);
        write_reg(CFG_RETRIES, 32'd3);
        send_item(1'b0, 1'b0, 1'b0, 32'h0);
        send_item(1'b1, 1'b1, 1'b0, 32'd7);
        send_item(1'b0, 1'b1, 1'b1, 32'd9);
        // shortest interval is still 60 s of ticks
        while (m_phase == PH_IDLE)
            send_item(1'b0, 1'b1, 1'b0, $urandom);
        send_item(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFE);
    endtask

    // result stall bursts
    initial begin
        int hold;
        hold        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 18);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_sched_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sched_expect_q.size() == 0) begin
                flag_mismatch("unexpected result beat", 32'h0, 32'h0);
            end else begin
                want = sched_expect_q.pop_front();
                if (o_phase !== want.phase)
                    flag_mismatch("phase", 32'(o_phase), 32'(want.phase));
                if (o_attempt_number !== want.tries)
                    flag_mismatch("attempt_number", 32'(o_attempt_number), 32'(want.tries));
                if (o_last_ok !== want.last_ok)
                    flag_mismatch("last_ok", 32'(o_last_ok), 32'(want.last_ok));
                if (o_last_sync_time !== want.last_sync)
                    flag_mismatch("last_sync_time", o_last_sync_time, want.last_sync);
                if (o_status_code !== want.status)
                    flag_mismatch("status_code", 32'(o_status_code), 32'(want.status));
                if (o_start_request !== want.start_req)
                    flag_mismatch("start_request", 32'(o_start_request), 32'(want.start_req));
                if (o_stop_request !== want.stop_req)
                    flag_mismatch("stop_request", 32'(o_stop_request), 32'(want.stop_req));
                if (o_accepted !== want.accepted)
                    flag_mismatch("accepted", 32'(o_accepted), 32'(want.accepted));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WatchdogLimit) begin
                    $display("%0t ns: no beat for %0d cycles", $realtime, WatchdogLimit);
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_INTERVAL;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_action     = 1'b0;
        i_network_up = 1'b0;
        i_sync_event = 1'b0;
        i_wall_time  = '0;

        cfg_interval_s = IntervalW'(21600);
        cfg_max_tries  = MaxRetriesReset;
        cfg_timeout_ms = TimeoutReset;
        cfg_min_wall   = MinValidReset;
        m_phase        = PH_IDLE;
        m_elapsed      = '0;
        m_wait         = '0;
        m_tries        = '0;
        m_fresh        = 1'b0;
        m_last_ok      = 1'b0;
        m_last_sync    = '0;
        m_status       = ST_NONE;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_en = 1'b1;

        check_basic_sequencing();
        check_register_clamping();
        check_retry_rounds();
        check_random_traffic();
        check_interval_expiry();

        wait_drained();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
